[rtl/core/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg: shared constants for the priority task scheduler
// Command, status and task mode codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int NUM_TASKS_DEF  = 16;
	localparam int NUM_LEVELS_DEF = 16;
	localparam int TICK_MS_DEF    = 55;

	localparam int CMD_W    = 3;
	localparam int ID_W     = 4;
	localparam int PRIO_W   = 4;
	localparam int MS_W     = 32;
	localparam int STATUS_W = 2;
	localparam int WOKEN_W  = 5;
	localparam int TICKS_W  = 32;
	localparam int LEFT_W   = 27;
	localparam int MODE_W   = 3;

	localparam logic [LEFT_W-1:0] SLEEP_MAX = {LEFT_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SLEEP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_READY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;

	localparam logic [MODE_W-1:0] MODE_UNUSED   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READY    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RUNNING  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SLEEPING = 3'd3;
	localparam logic [MODE_W-1:0] MODE_KILLED   = 3'd4;

endpackage

[rtl/core/pts_if.sv]
// ----------------------------------------------------------------------------
// pts_if: request and response channels of the scheduler
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pts_in_if;
	logic                              valid;
	logic                              ready;
	logic [pts_pkg::CMD_W-1:0]         command;
	logic [pts_pkg::ID_W-1:0]          task_id;
	logic [pts_pkg::PRIO_W-1:0]        priority_req;
	logic signed [pts_pkg::MS_W-1:0]   sleep_ms;

	modport source (output valid, command, task_id, priority_req, sleep_ms, input ready);
	modport sink   (input valid, command, task_id, priority_req, sleep_ms, output ready);
endinterface

interface pts_out_if;
	logic                          valid;
	logic                          ready;
	logic [pts_pkg::STATUS_W-1:0]  status;
	logic [pts_pkg::ID_W-1:0]      current_task;
	logic                          current_valid;
	logic [pts_pkg::WOKEN_W-1:0]   woken_count;
	logic [pts_pkg::TICKS_W-1:0]   tick_count;

	modport source (output valid, status, current_task, current_valid, woken_count,
		tick_count, input ready);
	modport sink   (input valid, status, current_task, current_valid, woken_count,
		tick_count, output ready);
endinterface

[rtl/core/pts_ram.sv]
// ----------------------------------------------------------------------------
// pts_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/priority_task_scheduler_sleep_unit.sv]
// Create passes through the create state; yield, exit and dispatch scan the level queues, through
// all NUM_LEVELS when every queue is empty; sleep first multiplies by the ms / TICK_MS reciprocal;
// tick walks the sleep list. Throughput: one request at a time; the next request is taken
// once the sequencer is back in idle, even while the previous response still waits on rsp.ready.
// Reset (arst_n low): all slots unused, queues and sleep list empty, no task
// running, tick count zero. Queue storage in RAM is not cleared.
// ----------------------------------------------------------------------------
// priority_task_scheduler_sleep_unit: multilevel FIFO task scheduler
// Per-level ready queues in one RAM, a sleep list, a running task and a tick
// counter, driven by a small sequencer around a constant reciprocal multiplier.
// ----------------------------------------------------------------------------
module priority_task_scheduler_sleep_unit #(
	parameter int NUM_TASKS  = pts_pkg::NUM_TASKS_DEF,
	parameter int NUM_LEVELS = pts_pkg::NUM_LEVELS_DEF,
	parameter int TICK_MS    = pts_pkg::TICK_MS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pts_in_if.sink     req,
	pts_out_if.source  rsp
);

	// task index, level index, fill count and RAM address widths
	localparam int TW    = $clog2(NUM_TASKS);
	localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int FW    = TW + 1;
	localparam int DEPTH = NUM_LEVELS * NUM_TASKS;
	localparam int AW    = $clog2(DEPTH);
	// ms / TICK_MS on the 31 magnitude bits of sleep_ms:
	// q = (ms * ceil(2^(31+L) / TICK_MS)) >> (31+L), L = clog2(TICK_MS); exact for ms < 2^31
	localparam int QW    = pts_pkg::MS_W - 1;
	localparam int DL    = $clog2(TICK_MS);
	localparam int SH    = QW + DL;
	localparam int MW    = QW + 1;
	localparam int PW    = QW + MW;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(TICK_MS - 1)) / 64'(TICK_MS);
	localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CREATE = 4'd1;
	localparam logic [3:0] S_TICK   = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_SLPFIN = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_TAKE   = 4'd6;
	localparam logic [3:0] S_RESP   = 4'd7;

	logic [3:0] state_q;

	// per-task state
	logic [pts_pkg::MODE_W-1:0] mode_q    [NUM_TASKS];
	logic [LW-1:0]              level_q   [NUM_TASKS];
	logic [pts_pkg::LEFT_W-1:0] left_q    [NUM_TASKS];
	logic                       forever_q [NUM_TASKS];
	// sleep list in insertion order
	logic [TW-1:0]              order_q   [NUM_TASKS];
	logic [FW-1:0]              len_q;
	// per-level queue pointers; entries live in the RAM
	logic [TW-1:0]              head_q    [NUM_LEVELS];
	logic [FW-1:0]              fill_q    [NUM_LEVELS];

	logic [TW-1:0]              run_task_q;
	logic                       run_valid_q;
	logic [pts_pkg::TICKS_W-1:0] ticks_q;

	// request context
	logic [TW-1:0]              tid_q;
	logic                       tid_ok_q;
	logic [LW-1:0]              prio_q;
	logic [pts_pkg::STATUS_W-1:0] status_q;
	logic [pts_pkg::WOKEN_W-1:0]  woken_q;
	logic [LW-1:0]              lv_q;
	logic [FW-1:0]              idx_q;
	logic [FW-1:0]              keep_q;

	// sleep time divide
	logic [QW-1:0]              ms_q;
	logic [PW-1:0]              prod_q;

	// response register
	logic                          out_valid_q;
	logic [pts_pkg::STATUS_W-1:0]  out_status_q;
	logic [pts_pkg::ID_W-1:0]      out_task_q;
	logic                          out_cur_q;
	logic [pts_pkg::WOKEN_W-1:0]   out_woken_q;
	logic [pts_pkg::TICKS_W-1:0]   out_ticks_q;

	logic in_fire;
	logic run_ok;
	logic create_ok;
	logic [pts_pkg::STATUS_W-1:0] in_status;
	logic [TW-1:0] tick_t;
	logic tick_busy;
	logic tick_dec;
	logic tick_wake;

	// make-ready: append a task to the tail of its level's queue
	logic          mr_fire;
	logic [TW-1:0] mr_task;
	logic [LW-1:0] mr_lv;
	logic [FW-1:0] mr_sum;
	logic [TW-1:0] mr_pos;

	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [TW-1:0] ram_rdata;

	logic [pts_pkg::MS_W-1:0] sleep_cnt;
	logic [pts_pkg::LEFT_W-1:0] sleep_sat;
	logic [FW-1:0] head_inc;

	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && req.ready;

	assign run_ok    = run_valid_q && (mode_q[run_task_q] == pts_pkg::MODE_RUNNING);
	assign create_ok = tid_ok_q && (mode_q[tid_q] == pts_pkg::MODE_UNUSED ||
		mode_q[tid_q] == pts_pkg::MODE_KILLED);

	// status decided at acceptance; create and pick outcomes follow later
	always_comb begin
		in_status = pts_pkg::ST_OK;
		case (req.command)
			pts_pkg::CMD_SLEEP, pts_pkg::CMD_YIELD, pts_pkg::CMD_EXIT: begin
				if (!run_ok) begin
					in_status = pts_pkg::ST_BAD;
				end
			end
			pts_pkg::CMD_DISPATCH: begin
				if (run_valid_q) begin
					in_status = pts_pkg::ST_BAD;
				end
			end
			default: begin
				in_status = pts_pkg::ST_OK;
			end
		endcase
	end

	// tick walk: one sleep-list entry per cycle
	assign tick_busy = (idx_q != len_q);
	assign tick_t    = order_q[idx_q[TW-1:0]];
	assign tick_dec  = !forever_q[tick_t] && (left_q[tick_t] != '0);
	assign tick_wake = tick_dec && (left_q[tick_t] == pts_pkg::LEFT_W'(1));

	always_comb begin
		mr_fire = 1'b0;
		mr_task = tid_q;
		mr_lv   = prio_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && req.command == pts_pkg::CMD_YIELD && run_ok) begin
					mr_fire = 1'b1;
					mr_task = run_task_q;
					mr_lv   = level_q[run_task_q];
				end
			end
			S_CREATE: begin
				mr_fire = create_ok;
			end
			S_TICK: begin
				mr_fire = tick_busy && tick_wake;
				mr_task = tick_t;
				mr_lv   = level_q[tick_t];
			end
			default: begin
				mr_fire = 1'b0;
			end
		endcase
	end

	assign mr_sum = FW'(head_q[mr_lv]) + fill_q[mr_lv];
	assign mr_pos = (mr_sum >= FW'(NUM_TASKS)) ? TW'(mr_sum - FW'(NUM_TASKS)) : TW'(mr_sum);

	assign ram_waddr = AW'(AW'(mr_lv) * AW'(NUM_TASKS)) + AW'(mr_pos);
	assign ram_raddr = AW'(AW'(lv_q) * AW'(NUM_TASKS)) + AW'(head_q[lv_q]);

	pts_ram #(
		.WIDTH (TW),
		.DEPTH (DEPTH)
	) u_ready_ram (
		.clk   (clk),
		.we    (mr_fire),
		.waddr (ram_waddr),
		.wdata (mr_task),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// quotient from the registered product, then +1 and saturate
	assign sleep_cnt = pts_pkg::MS_W'(prod_q >> SH) + pts_pkg::MS_W'(1);
	assign sleep_sat = (sleep_cnt > pts_pkg::MS_W'(pts_pkg::SLEEP_MAX)) ? pts_pkg::SLEEP_MAX :
		pts_pkg::LEFT_W'(sleep_cnt);

	assign head_inc = FW'(head_q[lv_q]) + FW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < NUM_TASKS; i++) begin
				mode_q[i]    <= pts_pkg::MODE_UNUSED;
				level_q[i]   <= '0;
				left_q[i]    <= '0;
				forever_q[i] <= 1'b0;
			end
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				fill_q[l] <= '0;
			end
			len_q       <= '0;
			run_task_q  <= '0;
			run_valid_q <= 1'b0;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// S_RESP handles the response register itself
			if (rsp.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			if (mr_fire) begin
				mode_q[mr_task] <= pts_pkg::MODE_READY;
				fill_q[mr_lv]   <= fill_q[mr_lv] + FW'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						woken_q  <= '0;
						status_q <= in_status;
						lv_q     <= '0;
						tid_q    <= TW'(req.task_id);
						tid_ok_q <= (32'(req.task_id) < NUM_TASKS);
						prio_q   <= (32'(req.priority_req) < NUM_LEVELS) ?
							LW'(req.priority_req) : LW'(NUM_LEVELS - 1);
						case (req.command)
							pts_pkg::CMD_CREATE: begin
								state_q <= S_CREATE;
							end
							pts_pkg::CMD_TICK: begin
								ticks_q <= ticks_q + 1'b1;
								idx_q   <= '0;
								keep_q  <= '0;
								state_q <= S_TICK;
							end
							pts_pkg::CMD_SLEEP, pts_pkg::CMD_YIELD, pts_pkg::CMD_EXIT: begin
								if (!run_ok) begin
									state_q  <= S_RESP;
								end else if (req.command == pts_pkg::CMD_SLEEP) begin
									if (req.sleep_ms[pts_pkg::MS_W-1]) begin
										forever_q[run_task_q] <= 1'b1;
										left_q[run_task_q]    <= '0;
										mode_q[run_task_q]    <= pts_pkg::MODE_SLEEPING;
										order_q[len_q[TW-1:0]] <= run_task_q;
										len_q       <= len_q + FW'(1);
										run_valid_q <= 1'b0;
										state_q     <= S_SCAN;
									end else begin
										ms_q    <= req.sleep_ms[QW-1:0];
										state_q <= S_DIV;
									end
								end else begin
									if (req.command == pts_pkg::CMD_EXIT) begin
										mode_q[run_task_q] <= pts_pkg::MODE_KILLED;
									end
									run_valid_q <= 1'b0;
									state_q     <= S_SCAN;
								end
							end
							pts_pkg::CMD_DISPATCH: begin
								if (run_valid_q) begin
									state_q  <= S_RESP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_CREATE: begin
					if (create_ok) begin
						level_q[tid_q]   <= prio_q;
						left_q[tid_q]    <= '0;
						forever_q[tid_q] <= 1'b0;
					end else begin
						status_q <= pts_pkg::ST_BAD;
					end
					state_q <= S_RESP;
				end
				S_TICK: begin
					if (tick_busy) begin
						if (tick_dec) begin
							left_q[tick_t] <= left_q[tick_t] - pts_pkg::LEFT_W'(1);
						end
						if (tick_wake) begin
							woken_q <= woken_q + pts_pkg::WOKEN_W'(1);
						end else begin
							order_q[keep_q[TW-1:0]] <= tick_t;
							keep_q <= keep_q + FW'(1);
						end
						idx_q <= idx_q + FW'(1);
					end else begin
						len_q   <= keep_q;
						state_q <= S_RESP;
					end
				end
				S_DIV: begin
					// one wide multiply by the constant reciprocal
					prod_q  <= PW'(ms_q) * PW'(RECIP);
					state_q <= S_SLPFIN;
				end
				S_SLPFIN: begin
					forever_q[run_task_q]  <= 1'b0;
					left_q[run_task_q]     <= sleep_sat;
					mode_q[run_task_q]     <= pts_pkg::MODE_SLEEPING;
					order_q[len_q[TW-1:0]] <= run_task_q;
					len_q       <= len_q + FW'(1);
					run_valid_q <= 1'b0;
					state_q     <= S_SCAN;
				end
				S_SCAN: begin
					// read of the head entry is issued at every scanned level
					if (fill_q[lv_q] != '0) begin
						state_q <= S_TAKE;
					end else if (lv_q == LW'(NUM_LEVELS - 1)) begin
						run_valid_q <= 1'b0;
						status_q    <= pts_pkg::ST_NO_READY;
						state_q     <= S_RESP;
					end else begin
						lv_q <= lv_q + LW'(1);
					end
				end
				S_TAKE: begin
					head_q[lv_q] <= (head_inc == FW'(NUM_TASKS)) ? '0 : TW'(head_inc);
					fill_q[lv_q] <= fill_q[lv_q] - FW'(1);
					mode_q[ram_rdata] <= pts_pkg::MODE_RUNNING;
					run_task_q  <= ram_rdata;
					run_valid_q <= 1'b1;
					state_q     <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_task_q   <= run_valid_q ? pts_pkg::ID_W'(run_task_q) : '0;
						out_cur_q    <= run_valid_q;
						out_woken_q  <= woken_q;
						out_ticks_q  <= ticks_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.current_task  = out_task_q;
	assign rsp.current_valid = out_cur_q;
	assign rsp.woken_count   = out_woken_q;
	assign rsp.tick_count    = out_ticks_q;

	// a running task is always marked running while idle
	a_run_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && run_valid_q) |-> mode_q[run_task_q] == pts_pkg::MODE_RUNNING)
		else $error("running task not in running mode");

	// the sleep list never holds more entries than slots
	a_sleep_len: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FW'(NUM_TASKS))
		else $error("sleep list overflow");

	// a tick request advances the tick counter by one
	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req.command == pts_pkg::CMD_TICK) |=> ticks_q == $past(ticks_q) + 1'b1)
		else $error("tick counter did not advance");

	// a pick only takes from a non-empty level
	a_take_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAKE) |-> fill_q[lv_q] != '0)
		else $error("pick from empty level");

endmodule
